// ===== rtl/dss_pkg.sv =====
// dss_pkg: shared widths, register codes, reset values and the result type
// of the delimiter string splitter. depends on nothing
package dss_pkg;

	localparam int BYTE_W        = 8;
	localparam int PART_W        = 16;
	localparam int DELIM_BYTES_W = 64;
	localparam int DELIM_LEN_W   = 4;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_INDEX_W   = 1;

	// defaults for the top-level parameters
	localparam int MAX_DELIMITER_DEF = 8;
	localparam int POSITION_BITS_DEF = 16;

	// result queue depth, must be a power of two and at least three
	localparam int OUTQ_DEPTH = 4;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_DELIM_BYTES  = 1'b0,
		CFG_DELIM_LENGTH = 1'b1
	} cfg_reg_t;

	localparam logic [DELIM_BYTES_W-1:0] DELIM_BYTES_RST  = 64'd10;
	localparam logic [DELIM_LEN_W-1:0]   DELIM_LENGTH_RST = 4'd1;

	typedef struct packed {
		logic [PART_W-1:0] part_start;
		logic [PART_W-1:0] part_length;
		logic              last_part;
		logic              overflow;
	} part_t;

endpackage

// ===== rtl/dss_in_if.sv =====
// dss_in_if: byte channel into the splitter, valid/ready with the byte payload
// depends on dss_pkg
interface dss_in_if import dss_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              has_byte;
	logic              end_of_string;

	modport source(output valid, data_byte, has_byte, end_of_string, input ready);
	modport sink(input valid, data_byte, has_byte, end_of_string, output ready);

endinterface

// ===== rtl/dss_out_if.sv =====
// dss_out_if: part channel out of the splitter, valid/ready with one part a beat
// depends on dss_pkg
interface dss_out_if import dss_pkg::*; ();

	logic              valid;
	logic              ready;
	logic [PART_W-1:0] part_start;
	logic [PART_W-1:0] part_length;
	logic              last_part;
	logic              overflow;

	modport source(output valid, part_start, part_length, last_part, overflow, input ready);
	modport sink(input valid, part_start, part_length, last_part, overflow, output ready);

endinterface

// ===== rtl/delimiter_string_splitter_top.sv =====
// Delimiter string splitter. A string arrives one byte a beat on the bytes channel and is cut
// on a delimiter of 1 to MAX_DELIMITER bytes (delimiter register, first byte in bits 7:0, and
// length register; length zero acts as one, lengths above MAX_DELIMITER are clamped). Matches
// are leftmost and non-overlapping. Each match gives one beat on the parts channel with the start
// offset and length of the text before it; a beat with end_of_string gives a final part marked
// last_part (possibly empty), after which the block starts a fresh string. A beat with has_byte
// low only carries the end mark; a beat with neither flag does nothing. Positions saturate at
// POSITION_BITS bits and overflow is then reported on every later part of that string; offsets
// are given in their low 16 bits. Throughput is one byte a cycle: the byte is registered, then
// the window compare and position arithmetic on it write its parts into a four-entry result
// queue. A byte that both closes a part and ends the string writes two parts, so a long run of
// such beats, or a stalled parts channel, is what holds the bytes channel off. A part shows on
// the parts channel after the beat that made it passes the input register and the result queue.
// Configuration writes are taken at once and must only happen while the block is idle.
module delimiter_string_splitter_top import dss_pkg::*; #(
	parameter int MAX_DELIMITER = MAX_DELIMITER_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	dss_in_if.sink                 bytes,
	dss_out_if.source              parts
);

	localparam int FILL_W = $clog2(MAX_DELIMITER + 1);
	localparam int IDX_W  = (MAX_DELIMITER > 1) ? $clog2(MAX_DELIMITER) : 1;
	localparam int DB_W   = BYTE_W * MAX_DELIMITER;
	localparam int QPTR_W = $clog2(OUTQ_DEPTH);
	localparam int QCNT_W = $clog2(OUTQ_DEPTH + 1);
	localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
	localparam logic [FILL_W-1:0]        FILL_MAX  = FILL_W'(MAX_DELIMITER);
	localparam logic [QCNT_W-1:0]        Q_ROOM_2  = QCNT_W'(OUTQ_DEPTH - 2);

	// low 16 bits of a position, zero-extended when positions are narrower
	function automatic logic [PART_W-1:0] to_part(input logic [POSITION_BITS-1:0] v);
		logic [POSITION_BITS+PART_W-1:0] w;
		w = (POSITION_BITS + PART_W)'(v);
		return w[PART_W-1:0];
	endfunction

	// configuration registers
	logic [DB_W-1:0]        delim_q;
	logic [DELIM_LEN_W-1:0] dlen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DB_W'(DELIM_BYTES_RST);
			dlen_q  <= DELIM_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_DELIM_BYTES: begin
					delim_q <= cfg_data[DB_W-1:0];
				end
				CFG_DELIM_LENGTH: begin
					dlen_q <= cfg_data[DELIM_LEN_W-1:0];
				end
			endcase
		end
	end

	// active delimiter length after the zero and upper clamps
	logic [FILL_W-1:0] n_act;

	always_comb begin
		priority if (dlen_q == '0) begin
			n_act = FILL_W'(1);
		end else if (dlen_q > DELIM_LEN_W'(MAX_DELIMITER)) begin
			n_act = FILL_MAX;
		end else begin
			n_act = FILL_W'(dlen_q);
		end
	end

	// input register stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              has_s1;
	logic              eos_s1;
	logic              s1_fire;
	logic              in_beat;

	// result queue
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	part_t             outq_q [OUTQ_DEPTH];
	logic              out_beat;

	// the stage moves on only when the queue can take two parts
	assign s1_fire     = valid_s1 && (cnt_q <= Q_ROOM_2);
	assign bytes.ready = !valid_s1 || s1_fire;
	assign in_beat     = bytes.valid && bytes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_beat || (valid_s1 && !s1_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			byte_s1 <= bytes.data_byte;
			has_s1  <= bytes.has_byte;
			eos_s1  <= bytes.end_of_string;
		end
	end

	// per-string state; the window needs no reset since only filled entries are compared
	logic [BYTE_W-1:0]        win_q [MAX_DELIMITER];
	logic [FILL_W-1:0]        fill_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] cps_q;
	logic                     sat_q;

	// next values for the byte in the stage
	logic [BYTE_W-1:0]        win_new [MAX_DELIMITER];
	logic [FILL_W-1:0]        fill_new;
	logic [POSITION_BITS-1:0] pos_new;
	logic                     sat_new;
	logic                     match;
	logic [POSITION_BITS-1:0] delim_start;
	logic [POSITION_BITS-1:0] len_m;
	logic [POSITION_BITS-1:0] cps_b;
	logic [POSITION_BITS-1:0] len_e;
	logic [POSITION_BITS-1:0] n_pos;

	// window shifted by one, newest byte in entry 0
	always_comb begin
		win_new[0] = byte_s1;
		for (int i = 1; i < MAX_DELIMITER; i++) begin
			win_new[i] = win_q[i-1];
		end
	end

	assign fill_new = (fill_q < FILL_MAX) ? fill_q + FILL_W'(1) : fill_q;

	// position counter with saturation
	always_comb begin
		pos_new = pos_q;
		sat_new = sat_q;
		if (has_s1) begin
			if (pos_q == POS_MAX) begin
				sat_new = 1'b1;
			end else begin
				pos_new = pos_q + POSITION_BITS'(1);
			end
		end
	end

	// parallel compare: delimiter byte k against window entry n-1-k
	always_comb begin
		logic [FILL_W-1:0] j;
		match = has_s1 && (fill_new >= n_act);
		for (int k = 0; k < MAX_DELIMITER; k++) begin
			j = n_act - FILL_W'(1) - FILL_W'(k);
			if ((FILL_W'(k) < n_act) && (win_new[j[IDX_W-1:0]] != delim_q[BYTE_W*k +: BYTE_W])) begin
				match = 1'b0;
			end
		end
	end

	// part boundaries; negative lengths (saturated positions) read as zero
	assign n_pos       = POSITION_BITS'(n_act);
	assign delim_start = (pos_new >= n_pos) ? pos_new - n_pos : '0;
	assign len_m       = (delim_start > cps_q) ? delim_start - cps_q : '0;
	assign cps_b       = match ? pos_new : cps_q;
	assign len_e       = (pos_new > cps_b) ? pos_new - cps_b : '0;

	part_t res_match;
	part_t res_end;
	part_t res_first;
	logic [1:0] n_push;

	always_comb begin
		res_match.part_start  = to_part(cps_q);
		res_match.part_length = to_part(len_m);
		res_match.last_part   = 1'b0;
		res_match.overflow    = sat_new;
		res_end.part_start    = to_part(cps_b);
		res_end.part_length   = to_part(len_e);
		res_end.last_part     = 1'b1;
		res_end.overflow      = sat_new;
	end

	// a matched part goes first, the final part after it
	assign res_first = match ? res_match : res_end;
	assign n_push    = s1_fire ? (2'(match) + 2'(eos_s1)) : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q  <= '0;
			cps_q  <= '0;
			sat_q  <= 1'b0;
		end else if (s1_fire) begin
			if (eos_s1) begin
				// end of string: fresh state for the next one
				fill_q <= '0;
				pos_q  <= '0;
				cps_q  <= '0;
				sat_q  <= 1'b0;
			end else if (has_s1) begin
				fill_q <= match ? '0 : fill_new;
				pos_q  <= pos_new;
				cps_q  <= cps_b;
				sat_q  <= sat_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && has_s1) begin
			win_q <= win_new;
		end
	end

	// result queue, up to two writes and one read a cycle
	assign out_beat = parts.valid && parts.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(n_push);
			rd_q  <= rd_q + QPTR_W'(out_beat);
			cnt_q <= cnt_q + QCNT_W'(n_push) - QCNT_W'(out_beat);
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			outq_q[wr_q] <= res_first;
		end
		if (n_push == 2'd2) begin
			outq_q[wr_q + QPTR_W'(1)] <= res_end;
		end
	end

	assign parts.valid       = (cnt_q != '0);
	assign parts.part_start  = outq_q[rd_q].part_start;
	assign parts.part_length = outq_q[rd_q].part_length;
	assign parts.last_part   = outq_q[rd_q].last_part;
	assign parts.overflow    = outq_q[rd_q].overflow;

endmodule

// ===== rtl/dss_checker.sv =====
// dss_checker: port-level checks on the parts channel of the splitter, bound to the top level
// depends on dss_pkg and delimiter_string_splitter_top
module dss_checker import dss_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [PART_W-1:0] part_start,
	input logic [PART_W-1:0] part_length,
	input logic              last_part,
	input logic              overflow
);

	logic out_beat;
	logic new_string_q;
	logic ovf_seen_q;

	assign out_beat = out_valid && out_ready;

	// tracks string boundaries and sticky overflow as seen on the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			new_string_q <= 1'b1;
			ovf_seen_q   <= 1'b0;
		end else if (out_beat) begin
			if (last_part) begin
				new_string_q <= 1'b1;
				ovf_seen_q   <= 1'b0;
			end else begin
				new_string_q <= 1'b0;
				ovf_seen_q   <= ovf_seen_q || overflow;
			end
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({part_start, part_length, last_part, overflow}))
		else $error("part beat changed while stalled");

	a_first_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && new_string_q |-> part_start == '0)
		else $error("first part of a string does not start at offset zero");

	a_overflow_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && ovf_seen_q |-> overflow)
		else $error("overflow dropped within a string");

endmodule

bind delimiter_string_splitter_top dss_checker u_dss_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (parts.valid),
	.out_ready   (parts.ready),
	.part_start  (parts.part_start),
	.part_length (parts.part_length),
	.last_part   (parts.last_part),
	.overflow    (parts.overflow)
);

// ===== tb/delimiter_string_splitter_top_tb.sv =====
`timescale 1ns / 1ps
// delimiter_string_splitter_top_tb: self-checking bench that feeds byte strings to the splitter
// and compares every part beat against parts predicted from the same bytes and registers
// depends on dss_pkg, dss_in_if, dss_out_if and delimiter_string_splitter_top
module delimiter_string_splitter_top_tb;
	import dss_pkg::*;

	localparam int RUN_LIMIT     = 3_000_000; // cycles, far above the slowest legal run
	localparam int SETTLE_CYCLES = 6;         // a part passes the input register and queue, keep margin
	localparam int PARK_CYCLES   = 300;       // long hold-off on the parts channel
	localparam int PHASE_ITEMS   = 140;       // byte or end beats per random phase
	localparam int WIN_DEPTH     = MAX_DELIMITER_DEF;
	localparam int LONG_BYTES    = 65620;     // enough bytes to run the position counter flat
	localparam logic [PART_W-1:0] POS_TOP = '1;

	// one beat on the bytes channel
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              has_byte;
		logic              end_of_string;
	} beat_t;

	// how the parts receiver behaves outside a long hold-off
	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_COIN,
		SINK_TRICKLE
	} sink_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	dss_in_if  byte_ch ();
	dss_out_if part_ch ();

	delimiter_string_splitter_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bytes     (byte_ch),
		.parts     (part_ch)
	);

	// predictor copy of the registers and of the per-string state
	logic [DELIM_BYTES_W-1:0] delim_now;
	logic [DELIM_LEN_W-1:0]   delim_len_now;
	logic [BYTE_W-1:0]        recent [WIN_DEPTH];
	int unsigned              recent_fill;
	logic [PART_W-1:0]        bytes_seen;
	logic [PART_W-1:0]        open_from;
	logic                     saturated;
	part_t                    parts_due [$];

	// sender side
	beat_t       beats_to_send [$];
	beat_t       offer;
	int unsigned n_queued = 0;
	int unsigned n_taken = 0;
	logic        hold_sender;
	logic        taken_last_edge = 1'b0;
	int unsigned gap_left = 0;
	int unsigned burst_left = 0;

	// receiver side
	int unsigned park_asked = 0;
	int unsigned park_done = 0;
	int unsigned park_left = 0;
	sink_mode_t  sink_mode = SINK_OPEN;
	int unsigned sink_mode_left = 0;

	int unsigned n_errors = 0;
	int unsigned cycle_count = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	// delimiter length as the block applies it: zero acts as one, clamp at the window
	function automatic int unsigned delim_span();
		if (delim_len_now == 0)
			return 1;
		if (delim_len_now > WIN_DEPTH)
			return WIN_DEPTH;
		return 32'(delim_len_now);
	endfunction

	function automatic void clear_string();
		foreach (recent[i])
			recent[i] = '0;
		recent_fill = 0;
		bytes_seen  = '0;
		open_from   = '0;
		saturated   = 1'b0;
	endfunction

	// a part from an offset up to an end offset, clipped at zero once positions saturate
	function automatic part_t make_part(logic [PART_W-1:0] from, logic [PART_W-1:0] upto,
			logic closing);
		part_t p;
		p.part_start  = from;
		p.part_length = (upto > from) ? upto - from : '0;
		p.last_part   = closing;
		p.overflow    = saturated;
		return p;
	endfunction

	// works out the parts one accepted beat produces and queues them in order
	task automatic predict_parts(beat_t b);
		int unsigned      n;
		bit               hit;
		logic [PART_W-1:0] cut;
		n = delim_span();
		if (b.has_byte) begin
			for (int i = WIN_DEPTH - 1; i > 0; i--)
				recent[i] = recent[i - 1];
			recent[0] = b.data_byte;
			if (recent_fill < WIN_DEPTH)
				recent_fill++;
			if (bytes_seen == POS_TOP)
				saturated = 1'b1;
			else
				bytes_seen++;
			// newest byte sits in entry 0, so the first delimiter byte is n-1 back
			hit = (recent_fill >= n);
			for (int k = 0; k < n; k++)
				if (recent[n - 1 - k] != delim_now[8 * k +: 8])
					hit = 1'b0;
			if (hit) begin
				cut = (bytes_seen >= n) ? bytes_seen - PART_W'(n) : '0;
				parts_due.push_back(make_part(open_from, cut, 1'b0));
				open_from   = bytes_seen;
				recent_fill = 0; // matched bytes cannot start another match
			end
		end
		if (b.end_of_string) begin
			parts_due.push_back(make_part(open_from, bytes_seen, 1'b1));
			clear_string();
		end
	endtask

	// ---------------------------------------------------------------- driver and monitors

	// sender: bursts of random length, random gaps between them, one offer held until taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!byte_ch.valid || taken_last_edge) begin
				if (gap_left != 0) begin
					byte_ch.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (hold_sender || beats_to_send.size() == 0) begin
					byte_ch.valid <= 1'b0;
				end else begin
					offer = beats_to_send.pop_front();
					byte_ch.data_byte     <= offer.data_byte;
					byte_ch.has_byte      <= offer.has_byte;
					byte_ch.end_of_string <= offer.end_of_string;
					byte_ch.valid         <= 1'b1;
					if (burst_left > 1) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(1, 32);
						// a third of bursts run straight on, now and then a long gap
						if ($urandom_range(0, 2) == 0)
							gap_left <= 0;
						else if ($urandom_range(0, 15) == 0)
							gap_left <= $urandom_range(10, 40);
						else
							gap_left <= $urandom_range(1, 5);
					end
				end
			end
		end
	end

	// accepted byte beats feed the predictor
	always @(posedge clk) begin
		taken_last_edge <= arst_n && byte_ch.valid && byte_ch.ready;
		if (arst_n && byte_ch.valid && byte_ch.ready) begin
			predict_parts('{byte_ch.data_byte, byte_ch.has_byte, byte_ch.end_of_string});
			n_taken++;
		end
	end

	// receiver: its own stall pattern, plus long hold-offs asked for by the stimulus
	always @(negedge clk) begin
		if (arst_n) begin
			if (park_asked != park_done) begin
				park_done <= park_done + 1;
				park_left <= PARK_CYCLES;
				part_ch.ready <= 1'b0;
			end else if (park_left != 0) begin
				park_left <= park_left - 1;
				part_ch.ready <= 1'b0;
			end else begin
				if (sink_mode_left == 0) begin
					sink_mode <= sink_mode_t'($urandom_range(0, 2));
					sink_mode_left <= $urandom_range(16, 160);
				end else begin
					sink_mode_left <= sink_mode_left - 1;
				end
				case (sink_mode)
				SINK_OPEN: begin
					part_ch.ready <= 1'b1;
				end
				SINK_COIN: begin
					part_ch.ready <= 1'($urandom_range(0, 1));
				end
				default: begin
					part_ch.ready <= ($urandom_range(0, 3) == 0);
				end
				endcase
			end
		end
	end

	task automatic check_part(part_t got);
		part_t want;
		want = parts_due.pop_front();
		if (got.part_start !== want.part_start) begin
			$error("part_start: expected %0d, got %0d", want.part_start, got.part_start);
			n_errors++;
		end
		if (got.part_length !== want.part_length) begin
			$error("part_length: expected %0d, got %0d", want.part_length, got.part_length);
			n_errors++;
		end
		if (got.last_part !== want.last_part) begin
			$error("last_part: expected %0b, got %0b", want.last_part, got.last_part);
			n_errors++;
		end
		if (got.overflow !== want.overflow) begin
			$error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
			n_errors++;
		end
	endtask

	// every part beat must match the oldest predicted part
	always @(posedge clk) begin
		if (arst_n && part_ch.valid && part_ch.ready) begin
			if (parts_due.size() == 0) begin
				$error("part beat with none due: start %0d length %0d last %0b",
					part_ch.part_start, part_ch.part_length, part_ch.last_part);
				n_errors++;
			end else begin
				check_part('{part_ch.part_start, part_ch.part_length, part_ch.last_part,
					part_ch.overflow});
			end
		end
	end

	// hard stop if the run hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("delimiter_string_splitter_top_tb: FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus helpers

	task automatic queue_beat(logic [BYTE_W-1:0] d, logic has, logic eos);
		beat_t b;
		b.data_byte     = d;
		b.has_byte      = has;
		b.end_of_string = eos;
		beats_to_send.push_back(b);
		n_queued++;
	endtask

	// idle means every queued beat taken and every predicted part seen, then a settling wait
	// for a byte that closed nothing but may still be in the pipe
	task automatic wait_idle();
		do @(negedge clk);
		while (n_taken != n_queued || parts_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// called at a falling edge with the block idle, so the predictor can follow at once
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		if (idx == CFG_DELIM_BYTES)
			delim_now = value;
		else
			delim_len_now = value[DELIM_LEN_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// delimiter drawn from two byte values, so it overlaps itself often
	function automatic logic [DELIM_BYTES_W-1:0] alpha_delim();
		logic [BYTE_W-1:0]        a;
		logic [BYTE_W-1:0]        b;
		logic [DELIM_BYTES_W-1:0] d;
		a = BYTE_W'($urandom_range(0, 255));
		b = BYTE_W'($urandom_range(0, 255));
		for (int k = 0; k < 8; k++)
			d[8 * k +: 8] = ($urandom_range(0, 2) != 0) ? a : b;
		return d;
	endfunction

	// one string: mostly delimiter bytes and whole delimiters, some scrambled strings,
	// now and then a dangling delimiter prefix and ignored beats in between
	task automatic queue_string(output int unsigned counted);
		int unsigned       len;
		int unsigned       made;
		int unsigned       n;
		int unsigned       pick;
		int unsigned       prefix;
		bit                scramble;
		logic [BYTE_W-1:0] d;
		n        = delim_span();
		scramble = ($urandom_range(0, 6) == 0);
		len      = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(0, 40);
		made     = 0;
		while (made < len) begin
			pick = $urandom_range(0, 9);
			if (!scramble && pick < 2 && made + n <= len) begin
				for (int k = 0; k < n; k++)
					queue_beat(delim_now[8 * k +: 8], 1'b1, 1'b0);
				made += n;
			end else begin
				if (scramble || pick == 9)
					d = BYTE_W'($urandom_range(0, 255));
				else
					d = delim_now[8 * $urandom_range(0, n - 1) +: 8];
				queue_beat(d, 1'b1, 1'b0);
				made++;
			end
			if ($urandom_range(0, 24) == 0)
				queue_beat(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
		end
		// broken match: start of the delimiter right before the end
		if (n > 1 && $urandom_range(0, 3) == 0) begin
			prefix = $urandom_range(1, n - 1);
			for (int k = 0; k < prefix; k++)
				queue_beat(delim_now[8 * k +: 8], 1'b1, 1'b0);
			made += prefix;
		end
		// end mark rides on the last byte or comes as a beat of its own
		if (made != 0 && $urandom_range(0, 1) == 0)
			beats_to_send[$].end_of_string = 1'b1;
		else
			queue_beat(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
		counted = made + 1;
	endtask

	// one setting of both registers, then random strings under it
	task automatic run_phase(logic [CFG_DATA_W-1:0] delim, logic [CFG_DATA_W-1:0] len_word,
			bit park, bit pause);
		int unsigned counted;
		int unsigned got;
		int unsigned base;
		int unsigned pause_at;
		wait_idle();
		write_reg(CFG_DELIM_BYTES, delim);
		write_reg(CFG_DELIM_LENGTH, len_word);
		@(posedge clk);
		base    = n_queued;
		counted = 0;
		while (counted < PHASE_ITEMS) begin
			queue_string(got);
			counted += got;
		end
		// receiver goes quiet while the sender keeps pushing: queue fills, bytes stall
		if (park)
			park_asked++;
		// sender stops halfway and waits for every part to drain
		if (pause) begin
			pause_at = base + (n_queued - base) / 2;
			do @(negedge clk);
			while (n_taken < pause_at);
			@(posedge clk);
			hold_sender = 1'b1;
			do @(negedge clk);
			while (byte_ch.valid || parts_due.size() != 0);
			repeat (SETTLE_CYCLES) @(negedge clk);
			@(posedge clk);
			hold_sender = 1'b0;
		end
	endtask

	// a single string long enough to saturate the position counter, with delimiters
	// packed in from just before that point so parts come out clipped to zero length
	task automatic run_long_string();
		int unsigned made;
		wait_idle();
		write_reg(CFG_DELIM_BYTES, alpha_delim());
		write_reg(CFG_DELIM_LENGTH, 2);
		@(posedge clk);
		made = 0;
		while (made < LONG_BYTES) begin
			if ((made >= 65525 && $urandom_range(0, 1) == 0) || $urandom_range(0, 1999) == 0) begin
				queue_beat(delim_now[7:0], 1'b1, 1'b0);
				queue_beat(delim_now[15:8], 1'b1, 1'b0);
				made += 2;
			end else begin
				queue_beat(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b0);
				made++;
			end
		end
		queue_beat(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		cfg_we                = 1'b0;
		cfg_index             = CFG_DELIM_BYTES;
		cfg_data              = '0;
		byte_ch.valid         = 1'b0;
		byte_ch.data_byte     = '0;
		byte_ch.has_byte      = 1'b0;
		byte_ch.end_of_string = 1'b0;
		part_ch.ready         = 1'b0;
		hold_sender           = 1'b0;
		delim_now             = DELIM_BYTES_RST;
		delim_len_now         = DELIM_LENGTH_RST;
		clear_string();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset delimiter, a single newline byte
		queue_beat(8'h5a, 1'b0, 1'b1); // end mark alone: empty final part
		queue_beat(8'hff, 1'b0, 1'b0); // neither flag: ignored
		queue_beat(8'h00, 1'b1, 1'b0);
		queue_beat(8'hff, 1'b1, 1'b0);
		queue_beat(8'h0a, 1'b1, 1'b0);
		queue_beat(8'h0a, 1'b1, 1'b1); // delimiter and end on the same beat: two parts
		queue_beat(8'h0a, 1'b1, 1'b0); // string opening with the delimiter
		queue_beat(8'h33, 1'b0, 1'b0);
		queue_beat(8'h71, 1'b1, 1'b0);
		queue_beat(8'h00, 1'b0, 1'b1);

		// length zero acts as one, delimiter is the zero byte
		wait_idle();
		write_reg(CFG_DELIM_LENGTH, 0);
		write_reg(CFG_DELIM_BYTES, '0);
		@(posedge clk);
		queue_beat(8'h00, 1'b0, 1'b0); // zero byte without has_byte must not match
		queue_beat(8'h80, 1'b1, 1'b0);
		queue_beat(8'h00, 1'b1, 1'b0);
		queue_beat(8'h00, 1'b1, 1'b1);

		// length fifteen clamps to eight, delimiter all ones
		wait_idle();
		write_reg(CFG_DELIM_LENGTH, 15);
		write_reg(CFG_DELIM_BYTES, '1);
		@(posedge clk);
		for (int i = 0; i < 8; i++)
			queue_beat(8'hff, 1'b1, 1'b0);
		queue_beat(8'hff, 1'b1, 1'b1); // ninth byte cannot reuse the matched ones

		run_phase({$urandom, $urandom}, 2, 1'b0, 1'b0);
		run_phase(alpha_delim(), 8, 1'b1, 1'b0);
		run_phase(alpha_delim(), 3, 1'b0, 1'b1);
		run_phase({$urandom, $urandom}, ({$urandom, $urandom} << 4) | 64'd1, 1'b0, 1'b0);
		run_long_string();
		run_phase(alpha_delim(), 9, 1'b0, 1'b0);
		run_phase('0, 4, 1'b1, 1'b0);
		run_phase(alpha_delim(), ({$urandom, $urandom} << 4) | 64'd5, 1'b0, 1'b1);
		run_phase(DELIM_BYTES_RST, DELIM_LENGTH_RST, 1'b0, 1'b0);

		wait_idle();
		if (n_errors == 0)
			$display("delimiter_string_splitter_top_tb: PASS");
		else
			$display("delimiter_string_splitter_top_tb: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/dss_pkg.sv
rtl/dss_in_if.sv
rtl/dss_out_if.sv
rtl/delimiter_string_splitter_top.sv
rtl/dss_checker.sv
tb/delimiter_string_splitter_top_tb.sv
